@@ rtl/core/sfdl_pkg.sv @@
// shared widths, types and register codes for the stereo feedback delay line
package sfdl_pkg;

  localparam int MAX_DELAY   = 262144;
  localparam int SAMPLE_BITS = 24;
  localparam int GAIN_BITS   = 16;

  localparam int ADDR_BITS   = $clog2(MAX_DELAY);
  localparam int LEN_BITS    = 19;
  localparam int FRAC_BITS   = GAIN_BITS - 1;
  localparam int PROD_BITS   = SAMPLE_BITS + GAIN_BITS + 1;
  localparam int SCALED_BITS = PROD_BITS + 1 - FRAC_BITS;
  localparam int SUM_BITS    = SCALED_BITS + 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = QPTR_BITS + 1;

  localparam int PADDR_BITS  = 4;
  localparam int PDATA_BITS  = 32;

  localparam logic [GAIN_BITS-1:0] GAIN_RESET  = GAIN_BITS'(6554);
  localparam logic [LEN_BITS-1:0]  DELAY_RESET = LEN_BITS'(12000);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum logic [1:0] {
    REG_ENABLE = 2'd0,
    REG_GAIN   = 2'd1,
    REG_DELAY  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    sample_t left_in;
    sample_t right_in;
    logic    host_silent;
    logic    block_end;
  } in_word_t;

  typedef struct packed {
    sample_t left_out;
    sample_t right_out;
    logic    out_last;
  } out_word_t;

  typedef struct packed {
    sample_t left;
    sample_t right;
  } store_entry_t;

  typedef struct packed {
    logic clear;
    logic fetch;
    logic commit;
  } store_req_t;

  typedef struct packed {
    logic rd_hit;
    logic len1;
  } store_stat_t;

  typedef struct packed {
    logic clear;
    logic commit;
    logic forward;
    logic rd_hit;
  } lane_ctl_t;

  typedef struct packed {
    in_word_t word;
    logic     act;
  } stage_t;

endpackage

@@ rtl/core/sfdl_store.sv @@
// delay store: single-port sample memory, write position and fill count
module sfdl_store (
  input  logic                                    clk,
  input  logic                                    rst,
  input  sfdl_pkg::store_req_t                    req,
  input  logic [sfdl_pkg::LEN_BITS-1:0]           delay_length,
  input  sfdl_pkg::store_entry_t                  wdata,
  output sfdl_pkg::store_entry_t                  rdata,
  output sfdl_pkg::store_stat_t                   stat
);
  import sfdl_pkg::*;

  store_entry_t         mem [MAX_DELAY];
  logic [ADDR_BITS-1:0] wpos;
  logic [ADDR_BITS-1:0] pos;
  logic [ADDR_BITS-1:0] npos;
  logic [ADDR_BITS-1:0] last_idx;
  logic [ADDR_BITS-1:0] addr;
  logic [ADDR_BITS:0]   eff_len;
  logic [ADDR_BITS:0]   fill;
  logic                 rd_hit;

  always_comb begin
    if (delay_length == '0) begin
      eff_len = (ADDR_BITS+1)'(1);
    end else if (32'(delay_length) > 32'(MAX_DELAY)) begin
      eff_len = (ADDR_BITS+1)'(MAX_DELAY);
    end else begin
      eff_len = (ADDR_BITS+1)'(delay_length);
    end
  end

  assign last_idx = ADDR_BITS'(eff_len - (ADDR_BITS+1)'(1));
  assign npos     = (wpos == last_idx) ? '0 : wpos + ADDR_BITS'(1);
  assign addr     = req.commit ? pos : npos;

  // entries at or above the fill count were never written since the last clear
  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      wpos <= '0;
      fill <= '0;
    end else begin
      if (req.fetch) begin
        wpos <= npos;
      end
      if (req.commit && ({1'b0, pos} == fill)) begin
        fill <= fill + (ADDR_BITS+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.fetch) begin
      pos    <= wpos;
      rd_hit <= ({1'b0, npos} < fill);
    end
  end

  always_ff @(posedge clk) begin
    if (req.commit) begin
      mem[addr] <= wdata;
    end else if (req.fetch) begin
      rdata <= mem[addr];
    end
  end

  assign stat.rd_hit = rd_hit;
  assign stat.len1   = (eff_len == (ADDR_BITS+1)'(1));

endmodule

@@ rtl/core/sfdl_lane.sv @@
// one channel lane: cached delayed sample, gain product, update and mix sums
module sfdl_lane (
  input  logic                              clk,
  input  logic                              rst,
  input  sfdl_pkg::lane_ctl_t               ctl,
  input  logic [sfdl_pkg::GAIN_BITS-1:0]    gain,
  input  sfdl_pkg::sample_t                 upd_in,
  input  sfdl_pkg::sample_t                 rd_data,
  output sfdl_pkg::sample_t                 upd_out,
  input  sfdl_pkg::sample_t                 mix_in,
  input  logic                              mix_act,
  output sfdl_pkg::sample_t                 mix_out
);
  import sfdl_pkg::*;

  localparam logic signed [PROD_BITS:0] ROUND_HALF = (PROD_BITS+1)'(1) << (FRAC_BITS - 1);

  // round to nearest, ties up: arithmetic shift of product plus half
  function automatic logic signed [SCALED_BITS-1:0] round_scale(
    input logic signed [PROD_BITS-1:0] p
  );
    logic signed [PROD_BITS:0] q;
    q = (PROD_BITS+1)'(p) + ROUND_HALF;
    return q[PROD_BITS:FRAC_BITS];
  endfunction

  function automatic sample_t sat_sum(
    input logic signed [SCALED_BITS-1:0] s,
    input sample_t                       x
  );
    logic signed [SUM_BITS-1:0]         t;
    logic [SUM_BITS-SAMPLE_BITS:0]      hi;
    t  = SUM_BITS'(s) + SUM_BITS'(x);
    hi = t[SUM_BITS-1:SAMPLE_BITS-1];
    if (&hi || !(|hi)) begin
      return t[SAMPLE_BITS-1:0];
    end else if (t[SUM_BITS-1]) begin
      return SAMPLE_MIN;
    end else begin
      return SAMPLE_MAX;
    end
  endfunction

  sample_t                        cache;
  sample_t                        delayed;
  logic signed [GAIN_BITS:0]      gain_s;
  logic signed [PROD_BITS-1:0]    prod;
  logic signed [SCALED_BITS-1:0]  scaled;

  assign gain_s  = {1'b0, gain};
  assign scaled  = round_scale(prod);
  assign upd_out = sat_sum(scaled, upd_in);
  assign mix_out = mix_act ? sat_sum(scaled, mix_in) : mix_in;

  // delay of one forwards the value just written
  assign delayed = ctl.forward ? upd_out : (ctl.rd_hit ? rd_data : '0);

  // cache holds the store entry at the current write position
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      cache <= '0;
    end else if (ctl.commit) begin
      cache <= delayed;
    end
  end

  always_ff @(posedge clk) begin
    prod <= PROD_BITS'(cache) * PROD_BITS'(gain_s);
  end

endmodule

@@ rtl/core/sfdl_merge.sv @@
// merge of both lanes into result words and the output queue
module sfdl_merge (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  sfdl_pkg::sample_t    left,
  input  sfdl_pkg::sample_t    right,
  input  logic                 last,
  output logic                 result_valid,
  input  logic                 result_stall,
  output sfdl_pkg::out_word_t  result_word
);
  import sfdl_pkg::*;

  out_word_t            queue [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] head;
  logic [QPTR_BITS-1:0] tail;
  logic [QCNT_BITS-1:0] count;
  logic                 pop;

  assign pop          = result_valid && !result_stall;
  assign result_valid = (count != '0);
  assign result_word  = queue[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= tail + QPTR_BITS'(1);
      end
      if (pop) begin
        head <= head + QPTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[tail] <= '{left_out: left, right_out: right, out_last: last};
    end
  end

endmodule

@@ rtl/core/stereo_feedback_delay_line_core.sv @@
// top level of the stereo feedback delay line (echo)
//
//   channel   direction  handshake                  word
//   sample    in         sample_valid/sample_stall  left_in, right_in, host_silent, block_end
//   result    out        result_valid/result_stall  left_out, right_out, out_last
//   config    in         psel/penable/pwrite        enable, feedback_gain, delay_length
//
// no word is taken in the cycle after an accept: the single-port store reads the next
// entry on accept and writes the updated entry in the cycle after, and the gain product
// of the cached entry is registered before the next word can use it.
// a result passes the stages s1, s2 and s3 on its way into the 4-word output queue.
// reset and a delay_length write empty the store at once through a fill count.
// sample_stall also rises during reset, on a config write and the cycle after it,
// and when the output queue has no room left for the words in flight.
module stereo_feedback_delay_line_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               sample_valid,
  output logic                               sample_stall,
  input  sfdl_pkg::in_word_t                 sample_word,
  output logic                               result_valid,
  input  logic                               result_stall,
  output sfdl_pkg::out_word_t                result_word,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sfdl_pkg::PADDR_BITS-1:0]    paddr,
  input  logic [sfdl_pkg::PDATA_BITS-1:0]    pwdata,
  output logic [sfdl_pkg::PDATA_BITS-1:0]    prdata,
  output logic                               pready
);
  import sfdl_pkg::*;

  logic                 enable;
  logic [GAIN_BITS-1:0] feedback_gain;
  logic [LEN_BITS-1:0]  delay_length;
  logic                 cfg_wr;
  logic                 cfg_wr_d;
  logic                 delay_wr;
  reg_idx_t             cfg_idx;

  logic                 accept;
  logic                 pop;
  logic [QCNT_BITS-1:0] inflight;
  logic                 v1;
  logic                 v2;
  logic                 v3;
  stage_t               s1;
  stage_t               s2;
  stage_t               s3;

  store_req_t           sreq;
  store_stat_t          sstat;
  store_entry_t         rdata;
  store_entry_t         wdata;
  lane_ctl_t            lctl;
  sample_t              mix_l;
  sample_t              mix_r;

  // configuration
  assign pready   = 1'b1;
  assign cfg_idx  = reg_idx_t'(paddr[3:2]);
  assign cfg_wr   = psel && penable && pwrite;
  assign delay_wr = cfg_wr && (cfg_idx == REG_DELAY);

  always_ff @(posedge clk) begin
    if (rst) begin
      enable        <= 1'b0;
      feedback_gain <= GAIN_RESET;
      delay_length  <= DELAY_RESET;
      cfg_wr_d      <= 1'b0;
    end else begin
      cfg_wr_d <= cfg_wr;
      if (cfg_wr) begin
        case (cfg_idx)
          REG_ENABLE: begin
            enable <= pwdata[0];
          end
          REG_GAIN: begin
            feedback_gain <= pwdata[GAIN_BITS-1:0];
          end
          REG_DELAY: begin
            delay_length <= pwdata[LEN_BITS-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ENABLE: prdata = PDATA_BITS'(enable);
      REG_GAIN:   prdata = PDATA_BITS'(feedback_gain);
      REG_DELAY:  prdata = PDATA_BITS'(delay_length);
      default:    prdata = '0;
    endcase
  end

  // input side and pipeline
  assign pop          = result_valid && !result_stall;
  assign sample_stall = rst || v1 || cfg_wr || cfg_wr_d ||
                        (inflight == QCNT_BITS'(QUEUE_DEPTH));
  assign accept       = sample_valid && !sample_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      inflight <= '0;
    end else begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
      if (accept && !pop) begin
        inflight <= inflight + QCNT_BITS'(1);
      end else if (pop && !accept) begin
        inflight <= inflight - QCNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.word <= sample_word;
      s1.act  <= enable && !sample_word.host_silent;
    end
    s2 <= s1;
    s3 <= s2;
  end

  assign sreq.clear  = delay_wr;
  assign sreq.fetch  = accept && enable && !sample_word.host_silent;
  assign sreq.commit = v1 && s1.act;

  assign lctl.clear   = delay_wr;
  assign lctl.commit  = sreq.commit;
  assign lctl.forward = sstat.len1;
  assign lctl.rd_hit  = sstat.rd_hit;

  sfdl_store u_store (
    .clk          (clk),
    .rst          (rst),
    .req          (sreq),
    .delay_length (delay_length),
    .wdata        (wdata),
    .rdata        (rdata),
    .stat         (sstat)
  );

  sfdl_lane u_lane_l (
    .clk     (clk),
    .rst     (rst),
    .ctl     (lctl),
    .gain    (feedback_gain),
    .upd_in  (s1.word.left_in),
    .rd_data (rdata.left),
    .upd_out (wdata.left),
    .mix_in  (s3.word.left_in),
    .mix_act (s3.act),
    .mix_out (mix_l)
  );

  sfdl_lane u_lane_r (
    .clk     (clk),
    .rst     (rst),
    .ctl     (lctl),
    .gain    (feedback_gain),
    .upd_in  (s1.word.right_in),
    .rd_data (rdata.right),
    .upd_out (wdata.right),
    .mix_in  (s3.word.right_in),
    .mix_act (s3.act),
    .mix_out (mix_r)
  );

  sfdl_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .push         (v3),
    .left         (mix_l),
    .right        (mix_r),
    .last         (s3.word.block_end),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word)
  );

endmodule

@@ rtl/core/sfdl_checker.sv @@
// port-level checks for the delay line top, bound to every instance
module sfdl_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 sample_valid,
  input logic                 sample_stall,
  input logic                 result_valid,
  input logic                 result_stall,
  input sfdl_pkg::out_word_t  result_word,
  input logic                 psel,
  input logic                 penable,
  input logic                 pwrite
);

  // a stalled result word holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result_word))
    else $error("result word changed while stalled");

  // no sample is taken in the cycle after a word is taken
  a_accept_spacing: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> sample_stall)
    else $error("sample taken in consecutive cycles");

  // no sample is taken right after a config write
  a_cfg_guard: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite |=> sample_stall)
    else $error("sample taken right after a config write");

  // reset empties the output queue
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule

bind stereo_feedback_delay_line_core sfdl_checker u_sfdl_checker (.*);
